### hdl/gbic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package gbic_pkg;

	localparam int ID_W          = 63;
	localparam int IDX_W         = 13;
	localparam int CNT_W         = 14;
	localparam int MAIN_ENTRIES  = 8192;
	localparam int MAIN_AW       = 13;
	localparam int GIVEN_ENTRIES = 4096;
	localparam int GIVEN_AW      = 12;
	localparam int GIVEN_CW      = 13;

	localparam logic [CNT_W-1:0]    MAIN_FULL  = CNT_W'(MAIN_ENTRIES);
	localparam logic [GIVEN_CW-1:0] GIVEN_FULL = GIVEN_CW'(GIVEN_ENTRIES);

	typedef enum logic [1:0] {
		OP_LOAD_DST = 2'd0,
		OP_LOAD_SRC = 2'd1,
		OP_EDGE     = 2'd2,
		OP_READ     = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_U,
		ST_INS_U,
		ST_SCAN_V,
		ST_GIVEN,
		ST_READ,
		ST_RDATA,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                main_we;
		logic [MAIN_AW-1:0]  main_waddr;
		logic                given_we;
		logic [GIVEN_AW-1:0] given_waddr;
		logic [ID_W-1:0]     wdata;
		logic [MAIN_AW-1:0]  raddr;
	} store_cmd_t;

endpackage
`default_nettype wire

### hdl/gbic_store.sv
`timescale 1ns / 1ps
`default_nettype none
module gbic_store (
	input  wire logic                     clk,
	input  wire gbic_pkg::store_cmd_t     cmd,
	output logic [gbic_pkg::ID_W-1:0]     main_rdata,
	output logic [gbic_pkg::ID_W-1:0]     given_rdata
);

	logic [gbic_pkg::ID_W-1:0] main_mem  [gbic_pkg::MAIN_ENTRIES];
	logic [gbic_pkg::ID_W-1:0] given_mem [gbic_pkg::GIVEN_ENTRIES];

	always_ff @(posedge clk) begin
		if (cmd.main_we) begin
			main_mem[cmd.main_waddr] <= cmd.wdata;
		end
		main_rdata <= main_mem[cmd.raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.given_we) begin
			given_mem[cmd.given_waddr] <= cmd.wdata;
		end
		given_rdata <= given_mem[cmd.raddr[gbic_pkg::GIVEN_AW-1:0]];
	end

endmodule
`default_nettype wire

### hdl/graph_block_id_compactor.sv
`timescale 1ns / 1ps
`default_nettype none
// One word is taken while busy is low and start is high; its result appears for one cycle
// with done high and cannot be held off. Lookups scan the id memory one entry per cycle from
// index zero. A destination load scans the main table and inserts the id on a miss; an edge
// scans for the source, inserts it on a miss outside given mode, then scans for the
// destination; a given source load appends to the given table when it has room; a readback
// reads one entry. The single read port of each id memory is why lookups scan in this way.
module graph_block_id_compactor (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic                          sources_given_we,
	input  wire logic                          sources_given_wd,
	input  wire logic [1:0]                    op,
	input  wire logic [gbic_pkg::ID_W-1:0]     node_id,
	input  wire logic [gbic_pkg::ID_W-1:0]     edge_dst_id,
	input  wire logic [gbic_pkg::IDX_W-1:0]    read_index,
	output logic                               done,
	output logic [gbic_pkg::IDX_W-1:0]         compact_src,
	output logic [gbic_pkg::IDX_W-1:0]         compact_dst,
	output logic [gbic_pkg::ID_W-1:0]          original_id,
	output logic [gbic_pkg::CNT_W-1:0]         source_count,
	output logic                               lookup_miss,
	output logic                               table_overflow
);

	gbic_pkg::state_t state_q, state_d;
	gbic_pkg::store_cmd_t cmd;

	logic                          cfg_q;
	gbic_pkg::op_t                 op_q;
	logic [gbic_pkg::CNT_W-1:0]    main_cnt_q;
	logic [gbic_pkg::GIVEN_CW-1:0] given_cnt_q;
	logic [gbic_pkg::CNT_W-1:0]    idx_q;
	logic                          rd_vld_s1;
	logic [gbic_pkg::CNT_W-1:0]    rd_idx_s1;
	logic [gbic_pkg::ID_W-1:0]     key_q, vkey_q;
	logic [gbic_pkg::IDX_W-1:0]    rix_q;
	logic [gbic_pkg::IDX_W-1:0]    csrc_q, cdst_q;
	logic [gbic_pkg::ID_W-1:0]     orig_q;
	logic                          miss_q, ovf_q;

	logic [gbic_pkg::ID_W-1:0]     main_rdata, given_rdata, rdata, cur_key;
	logic [gbic_pkg::CNT_W-1:0]    lim, cfg_cnt;
	logic accept, scanning, scan_given, issue, hit, fin, in_rng, main_ok, given_ok;

	assign accept     = start && (state_q == gbic_pkg::ST_IDLE);
	assign scanning   = (state_q == gbic_pkg::ST_SCAN_U) || (state_q == gbic_pkg::ST_SCAN_V);
	assign scan_given = (state_q == gbic_pkg::ST_SCAN_U) && (op_q == gbic_pkg::OP_EDGE) && cfg_q;
	assign cfg_cnt    = cfg_q ? {1'b0, given_cnt_q} : main_cnt_q;
	assign lim        = scan_given ? {1'b0, given_cnt_q} : main_cnt_q;
	assign rdata      = (scan_given || ((state_q == gbic_pkg::ST_RDATA) && cfg_q)) ?
			given_rdata : main_rdata;
	assign cur_key    = (state_q == gbic_pkg::ST_SCAN_V) ? vkey_q : key_q;
	assign issue      = scanning && (idx_q < lim);
	assign hit        = scanning && rd_vld_s1 && (rdata == cur_key);
	assign fin        = hit || (!issue && !rd_vld_s1);
	assign in_rng     = {1'b0, rix_q} < cfg_cnt;
	assign main_ok    = main_cnt_q < gbic_pkg::MAIN_FULL;
	assign given_ok   = given_cnt_q < gbic_pkg::GIVEN_FULL;

	always_comb begin
		state_d = state_q;
		case (state_q)
			gbic_pkg::ST_IDLE: begin
				if (start) begin
					case (gbic_pkg::op_t'(op))
						gbic_pkg::OP_LOAD_SRC: state_d = gbic_pkg::ST_GIVEN;
						gbic_pkg::OP_READ:     state_d = gbic_pkg::ST_READ;
						default:               state_d = gbic_pkg::ST_SCAN_U;
					endcase
				end
			end
			gbic_pkg::ST_SCAN_U: begin
				if (fin) begin
					if (op_q == gbic_pkg::OP_LOAD_DST) begin
						state_d = hit ? gbic_pkg::ST_DONE : gbic_pkg::ST_INS_U;
					end else if (cfg_q || hit) begin
						state_d = gbic_pkg::ST_SCAN_V;
					end else begin
						state_d = gbic_pkg::ST_INS_U;
					end
				end
			end
			gbic_pkg::ST_INS_U: begin
				state_d = (op_q == gbic_pkg::OP_EDGE) ? gbic_pkg::ST_SCAN_V : gbic_pkg::ST_DONE;
			end
			gbic_pkg::ST_SCAN_V: begin
				if (fin) begin
					state_d = gbic_pkg::ST_DONE;
				end
			end
			gbic_pkg::ST_GIVEN: state_d = gbic_pkg::ST_DONE;
			gbic_pkg::ST_READ:  state_d = gbic_pkg::ST_RDATA;
			gbic_pkg::ST_RDATA: state_d = gbic_pkg::ST_DONE;
			gbic_pkg::ST_DONE:  state_d = gbic_pkg::ST_IDLE;
			default:            state_d = gbic_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.main_we     = (state_q == gbic_pkg::ST_INS_U) && main_ok;
		cmd.main_waddr  = main_cnt_q[gbic_pkg::MAIN_AW-1:0];
		cmd.given_we    = (state_q == gbic_pkg::ST_GIVEN) && given_ok;
		cmd.given_waddr = given_cnt_q[gbic_pkg::GIVEN_AW-1:0];
		cmd.wdata       = key_q;
		cmd.raddr       = (state_q == gbic_pkg::ST_READ) ? rix_q :
				idx_q[gbic_pkg::MAIN_AW-1:0];
		busy            = (state_q != gbic_pkg::ST_IDLE);
		done            = (state_q == gbic_pkg::ST_DONE);
	end

	gbic_store u_store (
		.clk         (clk),
		.cmd         (cmd),
		.main_rdata  (main_rdata),
		.given_rdata (given_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gbic_pkg::ST_IDLE;
			cfg_q       <= 1'b0;
			op_q        <= gbic_pkg::OP_LOAD_DST;
			main_cnt_q  <= '0;
			given_cnt_q <= '0;
			idx_q       <= '0;
			rd_vld_s1   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (sources_given_we) begin
				cfg_q <= sources_given_wd;
			end
			if (accept) begin
				op_q <= gbic_pkg::op_t'(op);
			end
			if (cmd.main_we) begin
				main_cnt_q <= main_cnt_q + 1'b1;
			end
			if (cmd.given_we) begin
				given_cnt_q <= given_cnt_q + 1'b1;
			end
			if (!scanning || fin) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			rd_vld_s1 <= issue && !hit;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q;
		if (accept) begin
			key_q  <= node_id;
			vkey_q <= edge_dst_id;
			rix_q  <= read_index;
			csrc_q <= '0;
			cdst_q <= '0;
			orig_q <= '0;
			miss_q <= 1'b0;
			ovf_q  <= 1'b0;
		end
		case (state_q)
			gbic_pkg::ST_SCAN_U: begin
				if (hit) begin
					if (op_q == gbic_pkg::OP_LOAD_DST) begin
						cdst_q <= rd_idx_s1[gbic_pkg::IDX_W-1:0];
					end else begin
						csrc_q <= rd_idx_s1[gbic_pkg::IDX_W-1:0];
					end
				end else if (fin && cfg_q && (op_q == gbic_pkg::OP_EDGE)) begin
					miss_q <= 1'b1;
				end
			end
			gbic_pkg::ST_INS_U: begin
				if (main_ok) begin
					if (op_q == gbic_pkg::OP_LOAD_DST) begin
						cdst_q <= main_cnt_q[gbic_pkg::IDX_W-1:0];
					end else begin
						csrc_q <= main_cnt_q[gbic_pkg::IDX_W-1:0];
					end
				end else begin
					ovf_q <= 1'b1;
				end
			end
			gbic_pkg::ST_SCAN_V: begin
				if (hit) begin
					cdst_q <= rd_idx_s1[gbic_pkg::IDX_W-1:0];
				end else if (fin) begin
					miss_q <= 1'b1;
				end
			end
			gbic_pkg::ST_GIVEN: begin
				if (given_ok) begin
					csrc_q <= {1'b0, given_cnt_q[gbic_pkg::GIVEN_AW-1:0]};
				end else begin
					ovf_q <= 1'b1;
				end
			end
			gbic_pkg::ST_RDATA: begin
				orig_q <= in_rng ? rdata : '0;
				miss_q <= !in_rng;
			end
			default: begin
			end
		endcase
	end

	assign compact_src    = csrc_q;
	assign compact_dst    = cdst_q;
	assign original_id    = orig_q;
	assign source_count   = cfg_cnt;
	assign lookup_miss    = miss_q;
	assign table_overflow = ovf_q;

endmodule
`default_nettype wire

### hdl/gbic_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module gbic_props (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             start,
	input wire logic                             busy,
	input wire logic                             done,
	input wire logic [gbic_pkg::CNT_W-1:0]       source_count
);

	// A word that is taken keeps the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted word did not raise busy");

	// A result only appears while a word is in flight.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("result strobe while idle");

	// The block frees up right after a result.
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after result");

	// The source count never passes the table size.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> source_count <= gbic_pkg::MAIN_FULL) else $error("source count out of range");

endmodule

bind graph_block_id_compactor gbic_props u_gbic_props (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.source_count (source_count)
);
`default_nettype wire

### bench/gbic_checker.sv
`timescale 1ns / 1ps
module gbic_checker (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic                       busy,
	input  wire logic                       cfg_we,
	input  wire logic                       cfg_wd,
	input  wire logic [1:0]                 op,
	input  wire logic [gbic_pkg::ID_W-1:0]  node_id,
	input  wire logic [gbic_pkg::ID_W-1:0]  edge_dst_id,
	input  wire logic [gbic_pkg::IDX_W-1:0] read_index,
	input  wire logic                       done,
	input  wire logic [gbic_pkg::IDX_W-1:0] compact_src,
	input  wire logic [gbic_pkg::IDX_W-1:0] compact_dst,
	input  wire logic [gbic_pkg::ID_W-1:0]  original_id,
	input  wire logic [gbic_pkg::CNT_W-1:0] source_count,
	input  wire logic                       lookup_miss,
	input  wire logic                       table_overflow,
	output int                              fail_count,
	output int                              pending
);
	localparam int ID_W          = gbic_pkg::ID_W;
	localparam int IDX_W         = gbic_pkg::IDX_W;
	localparam int CNT_W         = gbic_pkg::CNT_W;
	localparam int MAIN_ENTRIES  = gbic_pkg::MAIN_ENTRIES;
	localparam int MAIN_AW       = gbic_pkg::MAIN_AW;
	localparam int GIVEN_ENTRIES = gbic_pkg::GIVEN_ENTRIES;
	localparam int GIVEN_AW      = gbic_pkg::GIVEN_AW;

	typedef struct packed {
		logic [IDX_W-1:0] csrc;
		logic [IDX_W-1:0] cdst;
		logic [ID_W-1:0]  orig;
		logic [CNT_W-1:0] scount;
		logic             miss;
		logic             ovf;
	} relabel_t;

	logic [ID_W-1:0] main_ids [MAIN_ENTRIES];
	logic [ID_W-1:0] given_ids [GIVEN_ENTRIES];
	int              main_cnt;
	int              given_cnt;
	logic            mode_given;
	relabel_t        relabel_q[$];
	int              mismatches;

	assign pending = relabel_q.size();

	function automatic int find_main_id(input logic [ID_W-1:0] key);
		for (int i = 0; i < main_cnt; i++)
			if (main_ids[MAIN_AW'(i)] == key)
				return i;
		return -1;
	endfunction

	function automatic int find_given_id(input logic [ID_W-1:0] key);
		for (int i = 0; i < given_cnt; i++)
			if (given_ids[GIVEN_AW'(i)] == key)
				return i;
		return -1;
	endfunction

	task automatic predict_word(input gbic_pkg::op_t o, input logic [ID_W-1:0] u,
			input logic [ID_W-1:0] v, input logic [IDX_W-1:0] rix);
		relabel_t r;
		int       k;
		r = '0;
		case (o)
			gbic_pkg::OP_LOAD_DST: begin
				k = find_main_id(u);
				if (k >= 0) begin
					r.cdst = IDX_W'(k);
				end else if (main_cnt < MAIN_ENTRIES) begin
					main_ids[MAIN_AW'(main_cnt)] = u;
					r.cdst = IDX_W'(main_cnt);
					main_cnt++;
				end else begin
					r.ovf = 1'b1;
				end
			end
			gbic_pkg::OP_LOAD_SRC: begin
				if (given_cnt < GIVEN_ENTRIES) begin
					given_ids[GIVEN_AW'(given_cnt)] = u;
					r.csrc = IDX_W'(given_cnt);
					given_cnt++;
				end else begin
					r.ovf = 1'b1;
				end
			end
			gbic_pkg::OP_EDGE: begin
				if (mode_given) begin
					k = find_given_id(u);
					if (k >= 0)
						r.csrc = IDX_W'(k);
					else
						r.miss = 1'b1;
				end else begin
					k = find_main_id(u);
					if (k >= 0) begin
						r.csrc = IDX_W'(k);
					end else if (main_cnt < MAIN_ENTRIES) begin
						main_ids[MAIN_AW'(main_cnt)] = u;
						r.csrc = IDX_W'(main_cnt);
						main_cnt++;
					end else begin
						r.ovf = 1'b1;
					end
				end
				k = find_main_id(v);
				if (k >= 0)
					r.cdst = IDX_W'(k);
				else
					r.miss = 1'b1;
			end
			default: begin
				if (mode_given) begin
					if (rix < given_cnt)
						r.orig = given_ids[rix[GIVEN_AW-1:0]];
					else
						r.miss = 1'b1;
				end else begin
					if (rix < main_cnt)
						r.orig = main_ids[rix];
					else
						r.miss = 1'b1;
				end
			end
		endcase
		r.scount = mode_given ? CNT_W'(given_cnt) : CNT_W'(main_cnt);
		relabel_q = {relabel_q, r};
	endtask

	task automatic note_mismatch(input relabel_t e, input relabel_t a);
		fail_count++;
		mismatches++;
		if (mismatches <= 10)
			$display("mismatch: expected src %0d dst %0d id %h cnt %0d miss %b ovf %b, %s",
				e.csrc, e.cdst, e.orig, e.scount, e.miss, e.ovf,
				$sformatf("got src %0d dst %0d id %h cnt %0d miss %b ovf %b",
				a.csrc, a.cdst, a.orig, a.scount, a.miss, a.ovf));
	endtask

	always @(posedge clk or negedge arst_n) begin
		relabel_t got;
		relabel_t want;
		if (!arst_n) begin
			main_cnt   = 0;
			given_cnt  = 0;
			mode_given = 1'b0;
			fail_count = 0;
			mismatches = 0;
			relabel_q.delete();
		end else begin
			if (done) begin
				got = '{compact_src, compact_dst, original_id, source_count,
					lookup_miss, table_overflow};
				if (relabel_q.size() == 0) begin
					want = '0;
					note_mismatch(want, got);
				end else begin
					want = relabel_q.pop_front();
					if (got !== want)
						note_mismatch(want, got);
				end
			end
			if (cfg_we)
				mode_given = cfg_wd;
			if (start && !busy)
				predict_word(gbic_pkg::op_t'(op), node_id, edge_dst_id, read_index);
		end
	end
endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;
	localparam int ID_W          = gbic_pkg::ID_W;
	localparam int IDX_W         = gbic_pkg::IDX_W;
	localparam int CNT_W         = gbic_pkg::CNT_W;
	localparam int GIVEN_ENTRIES = gbic_pkg::GIVEN_ENTRIES;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic             sources_given_we;
	logic             sources_given_wd;
	logic [1:0]       op;
	logic [ID_W-1:0]  node_id;
	logic [ID_W-1:0]  edge_dst_id;
	logic [IDX_W-1:0] read_index;
	logic             done;
	logic [IDX_W-1:0] compact_src;
	logic [IDX_W-1:0] compact_dst;
	logic [ID_W-1:0]  original_id;
	logic [CNT_W-1:0] source_count;
	logic             lookup_miss;
	logic             table_overflow;
	int               fail_count;
	int               pending;

	logic [ID_W-1:0] main_pool[$];
	logic [ID_W-1:0] given_pool[$];
	logic            mode_given;
	int              idle_pct;

	graph_block_id_compactor dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.sources_given_we(sources_given_we), .sources_given_wd(sources_given_wd),
		.op(op), .node_id(node_id), .edge_dst_id(edge_dst_id), .read_index(read_index),
		.done(done), .compact_src(compact_src), .compact_dst(compact_dst),
		.original_id(original_id), .source_count(source_count),
		.lookup_miss(lookup_miss), .table_overflow(table_overflow)
	);

	gbic_checker chk (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.cfg_we(sources_given_we), .cfg_wd(sources_given_wd),
		.op(op), .node_id(node_id), .edge_dst_id(edge_dst_id), .read_index(read_index),
		.done(done), .compact_src(compact_src), .compact_dst(compact_dst),
		.original_id(original_id), .source_count(source_count),
		.lookup_miss(lookup_miss), .table_overflow(table_overflow),
		.fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#40ms;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [ID_W-1:0] rand_id();
		return ID_W'({$urandom, $urandom});
	endfunction

	function automatic logic [ID_W-1:0] pick(ref logic [ID_W-1:0] q[$]);
		return q[$urandom_range(0, q.size() - 1)];
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_word(input gbic_pkg::op_t o, input logic [ID_W-1:0] u,
			input logic [ID_W-1:0] v, input logic [IDX_W-1:0] rix);
		if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
			start = 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		start       = 1'b1;
		op          = o;
		node_id     = u;
		edge_dst_id = v;
		read_index  = rix;
		while (busy)
			@(negedge clk);
		@(negedge clk);
		start = 1'b0;
		if (o == gbic_pkg::OP_LOAD_SRC && given_pool.size() < GIVEN_ENTRIES)
			given_pool = {given_pool, u};
	endtask

	task automatic load_dst(input logic [ID_W-1:0] u);
		bit seen;
		seen = 0;
		foreach (main_pool[i])
			if (main_pool[i] == u)
				seen = 1;
		send_word(gbic_pkg::OP_LOAD_DST, u, '0, '0);
		if (!seen)
			main_pool = {main_pool, u};
	endtask

	task automatic send_edge(input logic [ID_W-1:0] u, input logic [ID_W-1:0] v);
		bit seen;
		seen = 0;
		foreach (main_pool[i])
			if (main_pool[i] == u)
				seen = 1;
		send_word(gbic_pkg::OP_EDGE, u, v, '0);
		if (!mode_given && !seen)
			main_pool = {main_pool, u};
	endtask

	task automatic set_mode(input logic m);
		while (pending != 0 || busy)
			@(negedge clk);
		sources_given_we = 1'b1;
		sources_given_wd = m;
		@(negedge clk);
		sources_given_we = 1'b0;
		mode_given = m;
	endtask

	task automatic random_word();
		int              r;
		logic [ID_W-1:0] u;
		r = $urandom_range(0, 99);
		if (r < 10) begin
			if (main_pool.size() < 250 && $urandom_range(0, 2) != 0)
				load_dst(rand_id());
			else
				load_dst(pick(main_pool));
		end else if (r < 20) begin
			if (given_pool.size() < 200 && $urandom_range(0, 3) != 0)
				send_word(gbic_pkg::OP_LOAD_SRC, rand_id(), '0, '0);
			else
				send_word(gbic_pkg::OP_LOAD_SRC,
					given_pool.size() ? pick(given_pool) : rand_id(), '0, '0);
		end else if (r < 80) begin
			if (mode_given)
				u = (given_pool.size() && $urandom_range(0, 5) != 0) ?
					pick(given_pool) : rand_id();
			else
				u = (main_pool.size() >= 250 || $urandom_range(0, 2) != 0) ?
					pick(main_pool) : rand_id();
			send_edge(u, pick(main_pool));
		end else begin
			send_word(gbic_pkg::OP_READ, rand_id(), rand_id(),
				$urandom_range(0, 5) == 0 ? IDX_W'($urandom) :
				IDX_W'($urandom_range(0, 260)));
		end
	endtask

	initial begin
		int idles[4];
		idles = '{0, 47, 0, 17};
		arst_n = 1'b0;
		start = 1'b0;
		sources_given_we = 1'b0;
		sources_given_wd = 1'b0;
		op = gbic_pkg::OP_LOAD_DST;
		node_id = '0;
		edge_dst_id = '0;
		read_index = '0;
		mode_given = 1'b0;
		idle_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		set_mode(1'b0);
		send_word(gbic_pkg::OP_READ, '0, '0, '0);
		load_dst('0);
		load_dst('1);
		load_dst('1);
		send_edge(ID_W'(5), '1);
		send_edge(ID_W'(77), '0);
		send_edge(ID_W'(77), ID_W'(77));
		send_edge(ID_W'(5), '0);
		send_word(gbic_pkg::OP_READ, '0, '0, IDX_W'(3));
		send_word(gbic_pkg::OP_READ, '1, '1, '1);
		set_mode(1'b1);
		send_word(gbic_pkg::OP_READ, '0, '0, '0);
		send_word(gbic_pkg::OP_LOAD_SRC, '1, '0, '0);
		send_word(gbic_pkg::OP_LOAD_SRC, ID_W'(9), '0, '0);
		send_word(gbic_pkg::OP_LOAD_SRC, '1, '0, '0);
		send_edge('1, '0);
		send_edge(ID_W'(9), '1);
		send_edge(ID_W'(12345), '1);
		send_word(gbic_pkg::OP_READ, '0, '0, IDX_W'(2));
		send_word(gbic_pkg::OP_READ, '0, '0, IDX_W'(3));

		for (int p = 0; p < 4; p++) begin
			idle_pct = idles[p];
			for (int b = 0; b < 4; b++) begin
				set_mode(b == 0 ? 1'b0 : (b == 1 ? 1'b1 : 1'($urandom)));
				repeat (95)
					random_word();
			end
		end

		idle_pct = 0;
		set_mode(1'b1);
		send_word(gbic_pkg::OP_READ, '0, '0, IDX_W'(given_pool.size() - 1));
		send_word(gbic_pkg::OP_READ, '0, '0, IDX_W'(given_pool.size()));
		set_mode(1'b0);
		send_word(gbic_pkg::OP_READ, '0, '0, '1);

		while (pending != 0)
			@(negedge clk);
		repeat (600) @(negedge clk);
		if (fail_count == 0 && pending == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
